FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the top rtl file of the pid demux
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define TS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define TS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `TS_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

FILE: hw/rtl/ts_demux_pkg.sv
// ----------------------------------------------------------------------------
// ts_demux_pkg
// types and constants of the transport stream pid demux
// ----------------------------------------------------------------------------
package ts_demux_pkg;

  localparam int unsigned PacketBytes = 188;
  localparam int unsigned NumStreams  = 4;
  localparam int unsigned RouteRegs   = 4;

  localparam logic [7:0]  SyncByte    = 8'h47;
  localparam logic [41:0] PcrScale    = 42'd300;
  localparam int unsigned FlagAdapt   = 5;
  localparam int unsigned FlagPayload = 4;
  localparam int unsigned AfPcr       = 4;

  localparam int unsigned PidW   = 13;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned ClkW   = 42;
  localparam int unsigned BaseW  = 33;
  localparam int unsigned ExtW   = 9;
  localparam int unsigned CfgW   = 13;
  localparam int unsigned EnW    = 4;

  localparam int unsigned OutDataW  = IdxW + 8 + PidW + ClkW;
  localparam int unsigned OutTdataW = ((OutDataW + 7) / 8) * 8;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef logic [PidW-1:0] pid_t;
  typedef pid_t route_arr_t [RouteRegs];

  localparam route_arr_t RouteReset = '{13'h039, 13'h040, 13'h041, 13'h042};
  localparam logic [EnW-1:0] EnableReset = 4'hF;

  typedef enum logic [2:0] {
    RegRouteA = 3'd0,
    RegRouteB = 3'd1,
    RegRouteC = 3'd2,
    RegRouteD = 3'd3,
    RegEnable = 3'd4
  } ts_reg_e;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindPcr     = 2'd1,
    KindSync    = 2'd2
  } ts_kind_e;

  // one classified request from the parser to the output side
  typedef struct packed {
    ts_kind_e          kind;
    logic [IdxW-1:0]   stream_index;
    logic [7:0]        payload_byte;
    logic              last_of_packet;
    pid_t              packet_pid;
    logic [BaseW-1:0]  pcr_base;
    logic [ExtW-1:0]   pcr_ext;
  } ts_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ts_q_stat_t;

endpackage

FILE: hw/rtl/ts_demux_front.sv
// ----------------------------------------------------------------------------
// ts_demux_front
// packet parser: sync check, pid match, pcr capture and payload selection
// ----------------------------------------------------------------------------
module ts_demux_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [ts_demux_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_start_i,
  input  ts_demux_pkg::ts_q_stat_t      q_stat_i,
  output logic                          push_o,
  output ts_demux_pkg::ts_req_t         push_req_o
);

  ts_demux_pkg::route_arr_t             route_q;
  logic [ts_demux_pkg::EnW-1:0]         enable_q;

  logic [7:0]                           pos_q, pos_d;
  ts_demux_pkg::pid_t                   pid_q, pid_d;
  logic [7:0]                           flags_q, flags_d;
  logic [7:0]                           alen_q, alen_d;
  logic [ts_demux_pkg::IdxW-1:0]        midx_q, midx_d;
  logic                                 hit_q, hit_d;
  logic                                 drop_q, drop_d;
  logic [47:0]                          shift_q, shift_d;
  logic                                 pcr_q, pcr_d;

  logic                                 accept;
  logic                                 adapt;
  logic [8:0]                           pay_start;
  ts_demux_pkg::pid_t                   new_pid;
  logic                                 found;
  logic [ts_demux_pkg::IdxW-1:0]        found_idx;
  logic [47:0]                          shift_next;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_q  <= ts_demux_pkg::RouteReset;
      enable_q <= ts_demux_pkg::EnableReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ts_demux_pkg::RegRouteA,
        ts_demux_pkg::RegRouteB,
        ts_demux_pkg::RegRouteC,
        ts_demux_pkg::RegRouteD: route_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
        ts_demux_pkg::RegEnable: enable_q <= cfg_wdata_i[ts_demux_pkg::EnW-1:0];
        default: ;
      endcase
    end
  end

  // pid match, lowest entry wins
  assign new_pid = {pid_q[12:8], in_byte_i};
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < ts_demux_pkg::NumStreams; i++) begin
      if (!found && enable_q[i] && (route_q[i] == new_pid)) begin
        found     = 1'b1;
        found_idx = ts_demux_pkg::IdxW'(i);
      end
    end
  end

  assign adapt      = flags_q[ts_demux_pkg::FlagAdapt];
  assign pay_start  = adapt ? (9'd5 + {1'b0, alen_q}) : 9'd4;
  assign shift_next = {shift_q[39:0], in_byte_i};

  always_comb begin
    pos_d      = pos_q;
    pid_d      = pid_q;
    flags_d    = flags_q;
    alen_d     = alen_q;
    midx_d     = midx_q;
    hit_d      = hit_q;
    drop_d     = drop_q;
    shift_d    = shift_q;
    pcr_d      = pcr_q;
    push_o     = 1'b0;
    push_req_o = '0;
    push_req_o.kind = ts_demux_pkg::KindPayload;
    if (accept) begin
      if (in_start_i) begin
        pos_d   = '0;
        pid_d   = '0;
        flags_d = '0;
        alen_d  = '0;
        midx_d  = '0;
        hit_d   = 1'b0;
        shift_d = '0;
        pcr_d   = 1'b0;
        drop_d  = (in_byte_i != ts_demux_pkg::SyncByte);
        if (drop_d) begin
          push_o          = 1'b1;
          push_req_o.kind = ts_demux_pkg::KindSync;
        end else begin
          pos_d = 8'd1;
        end
      end else if (!drop_q && (pos_q < 8'(ts_demux_pkg::PacketBytes))) begin
        pos_d = pos_q + 8'd1;
        priority if (pos_q == 8'd1) begin
          pid_d = {in_byte_i[4:0], 8'h00};
        end else if (pos_q == 8'd2) begin
          pid_d  = new_pid;
          hit_d  = found;
          midx_d = found_idx;
        end else if (pos_q == 8'd3) begin
          flags_d = in_byte_i;
        end else if (adapt && (pos_q == 8'd4)) begin
          alen_d = in_byte_i;
        end else if ({1'b0, pos_q} >= pay_start) begin
          if (flags_q[ts_demux_pkg::FlagPayload] && hit_q) begin
            push_o                    = 1'b1;
            push_req_o.kind           = ts_demux_pkg::KindPayload;
            push_req_o.stream_index   = midx_q;
            push_req_o.payload_byte   = in_byte_i;
            push_req_o.last_of_packet =
              (pos_q == 8'(ts_demux_pkg::PacketBytes - 1));
            push_req_o.packet_pid     = pid_q;
          end
        end else if (pos_q == 8'd5) begin
          pcr_d = in_byte_i[ts_demux_pkg::AfPcr] && (alen_q >= 8'd7);
        end else if (pcr_q && (pos_q >= 8'd6) && (pos_q <= 8'd11)) begin
          shift_d = shift_next;
          if (pos_q == 8'd11) begin
            push_o                  = 1'b1;
            push_req_o.kind         = ts_demux_pkg::KindPcr;
            push_req_o.stream_index = hit_q ? midx_q : '0;
            push_req_o.packet_pid   = pid_q;
            push_req_o.pcr_base     = shift_next[47:15];
            push_req_o.pcr_ext      = shift_next[8:0];
          end
        end else begin
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      pid_q   <= '0;
      flags_q <= '0;
      alen_q  <= '0;
      midx_q  <= '0;
      hit_q   <= 1'b0;
      drop_q  <= 1'b1;
      shift_q <= '0;
      pcr_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      pid_q   <= pid_d;
      flags_q <= flags_d;
      alen_q  <= alen_d;
      midx_q  <= midx_d;
      hit_q   <= hit_d;
      drop_q  <= drop_d;
      shift_q <= shift_d;
      pcr_q   <= pcr_d;
    end
  end

endmodule

FILE: hw/rtl/ts_demux_queue.sv
// ----------------------------------------------------------------------------
// ts_demux_queue
// short request queue between parser and output stage
// ----------------------------------------------------------------------------
module ts_demux_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  ts_demux_pkg::ts_req_t    push_req_i,
  input  logic                     pop_i,
  output ts_demux_pkg::ts_req_t    pop_req_o,
  output ts_demux_pkg::ts_q_stat_t stat_o
);

  ts_demux_pkg::ts_req_t                 entry_q [ts_demux_pkg::QueueDepth];
  logic [ts_demux_pkg::QueuePtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [ts_demux_pkg::QueueCntW-1:0]    count_q;
  logic                                  do_push, do_pop;

  assign stat_o.full  = (count_q == ts_demux_pkg::QueueCntW'(ts_demux_pkg::QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_req_o    = entry_q[rd_ptr_q];

  function automatic logic [ts_demux_pkg::QueuePtrW-1:0] ptr_inc(
    input logic [ts_demux_pkg::QueuePtrW-1:0] p
  );
    if (p == ts_demux_pkg::QueuePtrW'(ts_demux_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ts_demux_back.sv
// ----------------------------------------------------------------------------
// ts_demux_back
// output stage: pcr scaling and registered result stream
// ----------------------------------------------------------------------------
module ts_demux_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ts_demux_pkg::ts_q_stat_t           q_stat_i,
  input  ts_demux_pkg::ts_req_t              req_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ts_demux_pkg::OutTdataW-1:0] out_data_o,
  output logic [1:0]                         out_user_o,
  output logic                               out_last_o
);

  logic                             valid_q;
  ts_demux_pkg::ts_kind_e           kind_q;
  logic [ts_demux_pkg::IdxW-1:0]    idx_q;
  logic [7:0]                       byte_q;
  logic                             last_q;
  ts_demux_pkg::pid_t               pid_q;
  logic [ts_demux_pkg::ClkW-1:0]    clk_ref_q, clk_ref_d;

  assign pop_o     = !q_stat_i.empty && (!valid_q || out_ready_i);
  assign clk_ref_d = ts_demux_pkg::ClkW'(req_i.pcr_base) * ts_demux_pkg::PcrScale
                   + ts_demux_pkg::ClkW'(req_i.pcr_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= !q_stat_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q    <= req_i.kind;
      idx_q     <= req_i.stream_index;
      byte_q    <= req_i.payload_byte;
      last_q    <= req_i.last_of_packet;
      pid_q     <= req_i.packet_pid;
      clk_ref_q <= clk_ref_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_user_o  = kind_q;
  assign out_last_o  = last_q;
  assign out_data_o  = {{(ts_demux_pkg::OutTdataW - ts_demux_pkg::OutDataW){1'b0}},
                        clk_ref_q, pid_q, byte_q, idx_q};

endmodule

FILE: hw/rtl/ts_packet_pid_demux.sv
// ----------------------------------------------------------------------------
// ts_packet_pid_demux
// transport stream pid filter and demux with pcr extraction
// ----------------------------------------------------------------------------
// input stream: one packet byte per request on s_axis, tuser set on the first
// byte of each packet. output stream: one request per payload byte of a routed
// packet, per pcr found in an adaptation field, and per bad sync byte; tuser
// carries the kind, tlast marks the final byte of a packet.
// routing pids and the enable mask are written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i; the user must write them only while the stream is idle, which the
// block itself does not enforce. indexes beyond the enable register are ignored.
// throughput is one byte per cycle while the request queue is not full.
// a result reaches m_axis through the request queue and the output register: the
// parser writes it into the four-entry request queue when its byte is accepted,
// and the output register, where the pcr is scaled by 300, then takes it from the queue.
// when the receiver stalls the queue fills and s_axis_tready drops once it
// holds four requests; nothing is lost.
// reset empties the queue, loads the default routing pids 0x39, 0x40, 0x41 and
// 0x42 with all entries enabled, and ignores bytes until the first packet start.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ts_packet_pid_demux (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [2:0]                         cfg_idx_i,
  input  logic [ts_demux_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // data_byte
  input  logic [7:0]                         s_axis_tdata,
  // packet_start
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // stream_index, payload_byte, packet_pid, clock_reference, zero fill
  output logic [ts_demux_pkg::OutTdataW-1:0] m_axis_tdata,
  // kind
  output logic [1:0]                         m_axis_tuser,
  // last_of_packet
  output logic                               m_axis_tlast
);

  logic                     push, pop;
  ts_demux_pkg::ts_req_t    push_req, pop_req;
  ts_demux_pkg::ts_q_stat_t q_stat;

  ts_demux_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_req_o  (push_req)
  );

  ts_demux_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .pop_req_o  (pop_req),
    .stat_o     (q_stat)
  );

  ts_demux_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .req_i       (pop_req),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  `TS_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && q_stat.full, "request pushed into full queue")
  `TS_ASSERT(a_clk_zero, clk_i, rst_ni, (m_axis_tvalid && (m_axis_tuser != ts_demux_pkg::KindPcr)) |-> (m_axis_tdata[64:23] == '0), "clock reference set outside pcr report")
  `TS_ASSERT(a_last_payload, clk_i, rst_ni, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == ts_demux_pkg::KindPayload), "last marker on non-payload result")
  `TS_ASSERT(a_pop_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |-> !pop, "queue popped while output stalled")

endmodule

FILE: verif/ts_packet_pid_demux_tb.sv
// ----------------------------------------------------------------------------
// ts_packet_pid_demux_tb
// self-checking testbench of the transport stream pid demux
// ----------------------------------------------------------------------------
// builds transport stream packets byte by byte: a short directed set for sync
// errors, stray bytes, pcr extremes and routed payload, then random packets
// with random headers, adaptation fields, pcr values and packet lengths, under
// several routing setups. a scoreboard class predicts every output request
// from the accepted input bytes and compares each accepted output field by
// field. both stream sides idle at random.
// ----------------------------------------------------------------------------
module ts_packet_pid_demux_tb;
  import ts_demux_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 8;
  localparam int PhaseBytes  = 100;
  localparam int NumPhases   = 6;

  typedef struct {
    ts_kind_e        kind;
    logic [IdxW-1:0] stream_index;
    logic [7:0]      payload_byte;
    logic            last_of_packet;
    pid_t            packet_pid;
    logic [ClkW-1:0] clock_reference;
  } demux_result_t;

  class demux_scoreboard;
    pid_t            route_pid [RouteRegs];
    logic [EnW-1:0]  route_en;
    logic [7:0]      byte_pos;
    pid_t            cur_pid;
    logic [7:0]      hdr_flags;
    logic [7:0]      af_len;
    logic [IdxW-1:0] hit_idx;
    logic            hit;
    logic            dropping;
    logic [47:0]     pcr_shift;
    logic            pcr_on;
    demux_result_t   expected_q [$];
    int              errors;

    function new();
      route_pid = RouteReset;
      route_en  = EnableReset;
      byte_pos  = '0;
      cur_pid   = '0;
      hdr_flags = '0;
      af_len    = '0;
      hit_idx   = '0;
      hit       = 1'b0;
      dropping  = 1'b1;
      pcr_shift = '0;
      pcr_on    = 1'b0;
      errors    = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [CfgW-1:0] val);
      if (idx < RegEnable) route_pid[idx] = val;
      else if (idx == RegEnable) route_en = val[EnW-1:0];
    endfunction

    function void add_result(ts_kind_e k, logic [IdxW-1:0] idx, logic [7:0] b, logic l,
                             pid_t p, logic [ClkW-1:0] c);
      demux_result_t r;
      r.kind            = k;
      r.stream_index    = idx;
      r.payload_byte    = b;
      r.last_of_packet  = l;
      r.packet_pid      = p;
      r.clock_reference = c;
      expected_q.push_back(r);
    endfunction

    function void note_byte(logic [7:0] d, logic s);
      logic [7:0]      pos;
      logic            adapt;
      int              pstart;
      logic [ClkW-1:0] pcr_val;
      if (s) begin
        byte_pos  = '0;
        cur_pid   = '0;
        hdr_flags = '0;
        af_len    = '0;
        hit_idx   = '0;
        hit       = 1'b0;
        pcr_shift = '0;
        pcr_on    = 1'b0;
        dropping  = (d != SyncByte);
        if (dropping) add_result(KindSync, '0, '0, 1'b0, '0, '0);
        else byte_pos = 8'd1;
        return;
      end
      if (dropping || byte_pos >= PacketBytes) return;
      pos      = byte_pos;
      byte_pos = pos + 8'd1;
      if (pos == 8'd1) begin
        cur_pid = {d[4:0], 8'h00};
        return;
      end
      if (pos == 8'd2) begin
        cur_pid[7:0] = d;
        hit          = 1'b0;
        hit_idx      = '0;
        // descending scan so the lowest matching entry wins
        for (int i = NumStreams - 1; i >= 0; i--) begin
          if (route_en[i] && route_pid[i] == cur_pid) begin
            hit     = 1'b1;
            hit_idx = IdxW'(i);
          end
        end
        return;
      end
      if (pos == 8'd3) begin
        hdr_flags = d;
        return;
      end
      adapt = hdr_flags[FlagAdapt];
      if (adapt && pos == 8'd4) begin
        af_len = d;
        return;
      end
      pstart = adapt ? 5 + int'(af_len) : 4;
      if (int'(pos) >= pstart) begin
        if (hdr_flags[FlagPayload] && hit)
          add_result(KindPayload, hit_idx, d, pos == 8'(PacketBytes - 1), cur_pid, '0);
        return;
      end
      if (pos == 8'd5) begin
        pcr_on = d[AfPcr] && af_len >= 8'd7;
        return;
      end
      if (pcr_on && pos >= 8'd6 && pos <= 8'd11) begin
        pcr_shift = {pcr_shift[39:0], d};
        if (pos == 8'd11) begin
          pcr_val = ClkW'(pcr_shift[47:15]) * PcrScale + ClkW'(pcr_shift[ExtW-1:0]);
          add_result(KindPcr, hit_idx, '0, 1'b0, cur_pid, pcr_val);
        end
      end
    endfunction

    function void check_result(logic [OutTdataW-1:0] td, logic [1:0] kind, logic tlast);
      demux_result_t   e;
      logic [IdxW-1:0] idx;
      logic [7:0]      b;
      pid_t            p;
      logic [ClkW-1:0] c;
      idx = td[IdxW-1:0];
      b   = td[IdxW+:8];
      p   = td[IdxW+8+:PidW];
      c   = td[IdxW+8+PidW+:ClkW];
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d pid %0h", kind, p);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (kind != e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, kind);
        errors++;
      end
      if (idx != e.stream_index) begin
        $error("stream_index: expected %0d, actual %0d", e.stream_index, idx);
        errors++;
      end
      if (b != e.payload_byte) begin
        $error("payload_byte: expected %0h, actual %0h", e.payload_byte, b);
        errors++;
      end
      if (tlast != e.last_of_packet) begin
        $error("last_of_packet: expected %0d, actual %0d", e.last_of_packet, tlast);
        errors++;
      end
      if (p != e.packet_pid) begin
        $error("packet_pid: expected %0h, actual %0h", e.packet_pid, p);
        errors++;
      end
      if (c != e.clock_reference) begin
        $error("clock_reference: expected %0d, actual %0d", e.clock_reference, c);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [2:0]           cfg_idx_i     = '0;
  logic [CfgW-1:0]      cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  demux_scoreboard sb = new();
  int idle_pct    = 20;
  int byte_count  = 0;
  int pkt_count   = 0;
  int cycle_count = 0;

  ts_packet_pid_demux dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  task automatic push_byte(input logic [7:0] d, input logic s);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= s;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(d, s);
    byte_count++;
  endtask

  task automatic send_packet(input logic [7:0] sync, input pid_t pid, input logic [7:0] flags,
                             input logic [7:0] alen, input logic [7:0] aflags,
                             input logic [47:0] pcr, input int len);
    logic [7:0] b;
    for (int p = 0; p < len; p++) begin
      if (p == 0) b = sync;
      else if (p == 1) b = {3'($urandom), pid[12:8]};
      else if (p == 2) b = pid[7:0];
      else if (p == 3) b = flags;
      else if (flags[FlagAdapt] && p == 4) b = alen;
      else if (flags[FlagAdapt] && p == 5) b = aflags;
      else if (flags[FlagAdapt] && p >= 6 && p <= 11) b = pcr[8*(11-p)+:8];
      else b = 8'($urandom);
      push_byte(b, p == 0);
    end
  endtask

  task automatic random_packet();
    logic [7:0]  sync;
    pid_t        pid;
    logic [7:0]  flags;
    logic [7:0]  alen;
    logic [47:0] pcr;
    int          len;
    sync = ($urandom_range(99) < 8) ? 8'($urandom) : SyncByte;
    case ($urandom_range(9))
      7:       pid = $urandom_range(1) ? '1 : '0;
      8, 9:    pid = PidW'($urandom);
      default: pid = sb.route_pid[$urandom_range(RouteRegs - 1)];
    endcase
    flags = 8'($urandom);
    if ($urandom_range(9) != 0) flags[FlagAdapt-:2] = 2'($urandom_range(1, 3));
    case ($urandom_range(9))
      0:             alen = 8'($urandom);
      1, 2, 3:       alen = 8'($urandom_range(0, PacketBytes - 5));
      default:       alen = 8'($urandom_range(0, 12));
    endcase
    pcr = {16'($urandom), 32'($urandom)};
    // some packets run to full length and past it
    if (pkt_count % 8 == 0 || $urandom_range(9) == 0)
      len = PacketBytes + $urandom_range(0, 4);
    else
      len = $urandom_range(1, 40);
    pkt_count++;
    send_packet(sync, pid, flags, alen, 8'($urandom), pcr, len);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_routes(input route_arr_t pids, input logic [EnW-1:0] en,
                                input bit stray_idx);
    logic [2:0]      idx;
    logic [CfgW-1:0] val;
    for (int i = 0; i < RouteRegs; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= ts_reg_e'(int'(RegRouteA) + i);
      cfg_wdata_i <= pids[i];
      @(posedge clk_i);
      sb.write_reg(ts_reg_e'(int'(RegRouteA) + i), pids[i]);
    end
    val         = {(CfgW - EnW)'($urandom), en};
    cfg_idx_i   <= RegEnable;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(RegEnable, val);
    if (stray_idx) begin
      idx         = 3'($urandom_range(int'(RegEnable) + 1, (1 << $bits(cfg_idx_i)) - 1));
      val         = CfgW'($urandom);
      cfg_idx_i   <= idx;
      cfg_wdata_i <= val;
      @(posedge clk_i);
      sb.write_reg(idx, val);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    route_arr_t pids;
    logic [EnW-1:0] en;
    int phase_end;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stray byte before any packet start, then a bad sync with a trailing byte
    push_byte(8'hFF, 1'b0);
    push_byte(8'h46, 1'b1);
    push_byte(SyncByte, 1'b0);
    // largest pcr with extension above 299, one payload byte
    send_packet(SyncByte, RouteReset[0], 8'h30, 8'd7, 8'h10, '1, 13);
    // zero pcr on an unrouted pid, adaptation field past the packet end
    send_packet(SyncByte, '1, 8'h20, 8'(PacketBytes - 5), 8'h10, '0, 12);
    // payload only packet
    send_packet(SyncByte, RouteReset[1], 8'h10, 8'h00, 8'h00, '0, 5);

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain();
      case (phase)
        0: begin
          pids = RouteReset;
          en   = EnableReset;
        end
        1: begin
          pids = '{default: '0};
          en   = '1;
        end
        2: begin
          pids = '{default: '1};
          en   = 4'b1010;
        end
        3: begin
          foreach (pids[i]) pids[i] = PidW'($urandom);
          en = '0;
        end
        default: begin
          foreach (pids[i]) pids[i] = PidW'($urandom_range(0, 8));
          en = EnW'($urandom);
        end
      endcase
      if (phase != 0) program_routes(pids, en, phase == 1 || phase == 4);
      idle_pct  = (phase == 4) ? 0 : 20;
      phase_end = byte_count + PhaseBytes;
      while (byte_count < phase_end) random_packet();
    end

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
